// File: src/xcpd_pkg.sv
// shared types and constants for the xor checked packet deframer
// no dependencies; used by every other file of the block except xcpd_stream_if
`default_nettype none

package xcpd_pkg;

  // input item: a received byte or one wait tick
  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } in_item_t;

  // result item: a data byte or an end-of-frame status
  typedef struct packed {
    logic       is_status;
    logic [7:0] byte_out;
    logic [7:0] byte_index;
    logic [7:0] frame_size;
    logic [2:0] status;
  } out_item_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_TIMEOUT   = 3'd3;
  localparam logic [2:0] ST_CSUM      = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SIZE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CSUM = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [7:0]  START_BYTE_RESET    = 8'd0;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd500;

endpackage

`default_nettype wire

// File: src/xcpd_stream_if.sv
// valid/ready stream channel carrying one item per handshake
// payload type is given by the instantiating module; uses no package
`default_nettype none

interface xcpd_stream_if #(
  parameter type payload_t = logic
) (
  input wire logic clk
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

`default_nettype wire

// File: src/xcpd_cfg.sv
// configuration registers: start byte and timeout in ticks
// depends on xcpd_pkg
`default_nettype none

module xcpd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [xcpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [xcpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic      [7:0]                       start_byte,
  output logic      [15:0]                      timeout_ticks
);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= xcpd_pkg::START_BYTE_RESET;
      timeout_ticks <= xcpd_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        xcpd_pkg::REG_START_BYTE: begin
          start_byte <= cfg_data[7:0];
        end
        xcpd_pkg::REG_TIMEOUT_TICKS: begin
          timeout_ticks <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/xcpd_core.sv
// frame state and per-item decode: phase, size, count, checksum, idle ticks
// depends on xcpd_pkg; result is combinational, registered by the top level
`default_nettype none

module xcpd_core #(
  parameter int unsigned MAX_DATA = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire xcpd_pkg::in_item_t  item,
  input  wire logic [7:0]          start_byte,
  input  wire logic [15:0]         timeout_ticks,
  output logic                     res_valid,
  output xcpd_pkg::out_item_t      res
);

  localparam logic [7:0] MaxData = 8'(MAX_DATA);

  logic [1:0]  phase;
  logic [7:0]  packet_size;
  logic [7:0]  data_count;
  logic [7:0]  running_xor;
  logic [15:0] idle_ticks;

  logic [1:0]  phase_next;
  logic [7:0]  packet_size_next;
  logic [7:0]  data_count_next;
  logic [7:0]  running_xor_next;
  logic [15:0] idle_ticks_next;

  logic [15:0] ticks_inc;
  logic [7:0]  count_inc;
  logic        finish;
  logic [2:0]  finish_status;
  logic [7:0]  finish_size;

  assign ticks_inc = (idle_ticks == 16'hffff) ? idle_ticks : idle_ticks + 16'd1;
  assign count_inc = data_count + 8'd1;

  always_comb begin
    phase_next       = phase;
    packet_size_next = packet_size;
    data_count_next  = data_count;
    running_xor_next = running_xor;
    idle_ticks_next  = idle_ticks;
    finish           = 1'b0;
    finish_status    = xcpd_pkg::ST_OK;
    finish_size      = packet_size;
    res_valid        = 1'b0;
    res              = '0;

    if (item.kind == xcpd_pkg::KIND_TICK) begin
      if (timeout_ticks != 16'd0) begin
        if (ticks_inc >= timeout_ticks) begin
          idle_ticks_next = 16'd0;
          finish          = 1'b1;
          finish_status   = xcpd_pkg::ST_TIMEOUT;
        end else begin
          idle_ticks_next = ticks_inc;
        end
      end
    end else begin
      idle_ticks_next = 16'd0;
      case (phase)
        xcpd_pkg::PH_IDLE: begin
          if (item.byte_in != start_byte) begin
            finish        = 1'b1;
            finish_status = xcpd_pkg::ST_BAD_START;
          end else begin
            phase_next       = xcpd_pkg::PH_SIZE;
            packet_size_next = 8'd0;
            data_count_next  = 8'd0;
            running_xor_next = 8'd0;
          end
        end
        xcpd_pkg::PH_SIZE: begin
          packet_size_next = item.byte_in;
          if (item.byte_in > MaxData) begin
            finish        = 1'b1;
            finish_status = xcpd_pkg::ST_TOO_LARGE;
            finish_size   = item.byte_in;
          end else begin
            running_xor_next = item.byte_in;
            phase_next = (item.byte_in == 8'd0) ? xcpd_pkg::PH_CSUM : xcpd_pkg::PH_DATA;
          end
        end
        xcpd_pkg::PH_DATA: begin
          res_valid        = 1'b1;
          res.is_status    = 1'b0;
          res.byte_out     = item.byte_in;
          res.byte_index   = data_count;
          res.frame_size   = packet_size;
          res.status       = xcpd_pkg::ST_OK;
          running_xor_next = running_xor ^ item.byte_in;
          data_count_next  = count_inc;
          if (count_inc >= packet_size) begin
            phase_next = xcpd_pkg::PH_CSUM;
          end
        end
        default: begin
          finish        = 1'b1;
          finish_status = (item.byte_in == running_xor) ? xcpd_pkg::ST_OK
                                                        : xcpd_pkg::ST_CSUM;
        end
      endcase
    end

    if (finish) begin
      res_valid        = 1'b1;
      res.is_status    = 1'b1;
      res.byte_out     = 8'd0;
      res.byte_index   = data_count;
      res.frame_size   = finish_size;
      res.status       = finish_status;
      phase_next       = xcpd_pkg::PH_IDLE;
      packet_size_next = 8'd0;
      data_count_next  = 8'd0;
      running_xor_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= xcpd_pkg::PH_IDLE;
      packet_size <= 8'd0;
      data_count  <= 8'd0;
      running_xor <= 8'd0;
      idle_ticks  <= 16'd0;
    end else if (step) begin
      phase       <= phase_next;
      packet_size <= packet_size_next;
      data_count  <= data_count_next;
      running_xor <= running_xor_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

endmodule

`default_nettype wire

// File: src/xor_checked_packet_deframer_top.sv
// top level of the xor checked packet deframer: input register, core, result register
// depends on xcpd_pkg, xcpd_stream_if, xcpd_cfg and xcpd_core
`default_nettype none

// Takes one item per cycle, bytes and wait ticks alike, unless a stalled result holds the
// pipeline. An accepted item sits in the input register while the frame state update and
// decode run, and its result then lands in the result register, which drives the output.
// A stalled result holds the pipeline only when both registers are full; items that cause
// no result (header bytes, ticks below the timeout) pass through the core without waiting
// on the result side. Configuration is written through a plain write port (index 0 start
// byte, index 1 timeout ticks); the user must write it only while the block is idle, as
// the block itself does not enforce this. MAX_DATA is the largest accepted frame size.
module xor_checked_packet_deframer_top #(
  parameter int unsigned MAX_DATA = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  xcpd_stream_if.sink                           bytes,
  xcpd_stream_if.source                         results,
  input  wire logic                             cfg_wr_en,
  input  wire logic [xcpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [xcpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [7:0] MaxData = 8'(MAX_DATA);

  logic [7:0]          start_byte;
  logic [15:0]         timeout_ticks;

  logic                hold_valid;
  xcpd_pkg::in_item_t  hold_item;
  logic                advance;
  logic                hold_fire;

  logic                res_valid;
  xcpd_pkg::out_item_t res;

  logic                out_valid;
  xcpd_pkg::out_item_t out_item;

  xcpd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start_byte    (start_byte),
    .timeout_ticks (timeout_ticks)
  );

  // result slot free or being drained this cycle
  assign advance   = !out_valid || results.ready;
  assign hold_fire = hold_valid && (advance || !res_valid);
  assign bytes.ready = !hold_valid || hold_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (bytes.ready) begin
      hold_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      hold_item <= bytes.payload;
    end
  end

  xcpd_core #(
    .MAX_DATA (MAX_DATA)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (hold_fire),
    .item          (hold_item),
    .start_byte    (start_byte),
    .timeout_ticks (timeout_ticks),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire && res_valid) begin
      out_item <= res;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_item;

  // data items always carry ok status and an index inside the frame
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.is_status) |->
      (out_item.status == xcpd_pkg::ST_OK && out_item.byte_index < out_item.frame_size
       && out_item.frame_size <= MaxData))
    else $error("data item with bad status, index or size");

  // size rejection only for sizes above the limit, with no data counted
  a_too_large: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.is_status && out_item.status == xcpd_pkg::ST_TOO_LARGE) |->
      (out_item.frame_size > MaxData && out_item.byte_index == 8'd0))
    else $error("size error on an acceptable size");

  // a result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !(hold_fire && res_valid))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/xor_checked_packet_deframer_top_tb.sv
// self-checking testbench for xor_checked_packet_deframer_top: a directed table, then
// random frames, noise and tick runs under several register settings, checked against
// a built-in deframer; depends on xcpd_pkg, xcpd_stream_if and the block's top level
`timescale 1ns / 1ps

module xor_checked_packet_deframer_top_tb;
  import xcpd_pkg::*;

  localparam int FRAME_MAX = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic      kind;
    logic [7:0] data;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  xcpd_stream_if #(.payload_t(in_item_t)) bytes_if (.clk(clk));
  xcpd_stream_if #(.payload_t(out_item_t)) results_if (.clk(clk));

  xor_checked_packet_deframer_top #(.MAX_DATA(FRAME_MAX)) uut (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_if),
    .results(results_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // deframer state as seen by the predictor
  logic [7:0] cfg_start = START_BYTE_RESET;
  logic [15:0] cfg_timeout = TIMEOUT_TICKS_RESET;
  logic [1:0] frm_phase = PH_IDLE;
  logic [7:0] frm_size = 8'd0;
  logic [7:0] frm_count = 8'd0;
  logic [7:0] frm_xor = 8'd0;
  logic [15:0] tick_count = 16'd0;

  out_item_t deframed_q[$];
  int fails = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  dir_row_t dir_rows [0:22] = '{
    '{KIND_BYTE, 8'hFF, 1'b1, '{1'b1, 8'h00, 8'd0, 8'd0, ST_BAD_START}},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'hFF, 1'b1, '{1'b1, 8'h00, 8'd0, 8'd255, ST_TOO_LARGE}},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'h00, 1'b1, '{1'b1, 8'h00, 8'd0, 8'd0, ST_OK}},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'h5A, 1'b1, '{1'b1, 8'h00, 8'd0, 8'd0, ST_CSUM}},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'h41, 1'b1, '{1'b1, 8'h00, 8'd0, 8'd65, ST_TOO_LARGE}},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'h03, 1'b0, '0},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_TICK, 8'hFF, 1'b0, '0},
    '{KIND_BYTE, 8'hFF, 1'b0, '0},
    '{KIND_BYTE, 8'h80, 1'b0, '0},
    '{KIND_BYTE, 8'h7C, 1'b1, '{1'b1, 8'h00, 8'd3, 8'd3, ST_OK}},
    '{KIND_BYTE, 8'h00, 1'b0, '0},
    '{KIND_BYTE, 8'h01, 1'b0, '0},
    '{KIND_BYTE, 8'h01, 1'b0, '0},
    '{KIND_BYTE, 8'hFF, 1'b1, '{1'b1, 8'h00, 8'd1, 8'd1, ST_CSUM}},
    '{KIND_TICK, 8'h00, 1'b0, '0}
  };

  function automatic out_item_t close_frame(input logic [2:0] st);
    out_item_t r;
    r = '{1'b1, 8'h00, frm_count, frm_size, st};
    frm_phase = PH_IDLE;
    frm_size = 8'd0;
    frm_count = 8'd0;
    frm_xor = 8'd0;
    return r;
  endfunction

  function automatic bit deframe_step(input logic kind, input logic [7:0] b,
                                      output out_item_t r);
    bit emit;
    emit = 1'b0;
    r = '0;
    if (kind == KIND_TICK) begin
      if (cfg_timeout != 16'd0) begin
        if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
        if (tick_count >= cfg_timeout) begin
          tick_count = 16'd0;
          r = close_frame(ST_TIMEOUT);
          emit = 1'b1;
        end
      end
    end else begin
      tick_count = 16'd0;
      case (frm_phase)
        PH_IDLE: begin
          if (b != cfg_start) begin
            r = close_frame(ST_BAD_START);
            emit = 1'b1;
          end else begin
            frm_phase = PH_SIZE;
            frm_size = 8'd0;
            frm_count = 8'd0;
            frm_xor = 8'd0;
          end
        end
        PH_SIZE: begin
          frm_size = b;
          if (b > FRAME_MAX) begin
            r = close_frame(ST_TOO_LARGE);
            emit = 1'b1;
          end else begin
            frm_xor = b;
            frm_phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          r = '{1'b0, b, frm_count, frm_size, ST_OK};
          emit = 1'b1;
          frm_xor = frm_xor ^ b;
          frm_count = frm_count + 8'd1;
          if (frm_count >= frm_size) frm_phase = PH_CSUM;
        end
        default: begin
          r = close_frame((b == frm_xor) ? ST_OK : ST_CSUM);
          emit = 1'b1;
        end
      endcase
    end
    return emit;
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] b,
                           input bit typed = 1'b0, input out_item_t want = '0);
    out_item_t got;
    bit emit;
    while (idle_on && $urandom_range(0, 99) < 21) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.payload <= '{kind, b};
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    emit = deframe_step(kind, b, got);
    if (typed) deframed_q.push_back(want);
    else if (emit) deframed_q.push_back(got);
    items_sent++;
  endtask

  // stop offering, let every pending item come out, then give in-flight ticks time to pass
  task automatic settle();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] start, input logic [15:0] ticks);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_data <= {8'h00, start};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_start = start;
    cfg_timeout = ticks;
  endtask

  task automatic send_burst();
    int pick;
    int len;
    logic [7:0] sz;
    logic [7:0] x;
    logic [7:0] d;
    logic [7:0] flip;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      case ($urandom_range(0, 9))
        0: sz = 8'd0;
        1: sz = 8'(FRAME_MAX);
        2: sz = 8'($urandom_range(0, FRAME_MAX));
        default: sz = 8'($urandom_range(1, 6));
      endcase
      send_item(KIND_BYTE, cfg_start);
      send_item(KIND_BYTE, sz);
      x = sz;
      for (int i = 0; i < sz; i++) begin
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 6) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
        send_item(KIND_BYTE, d);
        x = x ^ d;
      end
      if ($urandom_range(0, 9) == 0) begin
        flip = 8'($urandom_range(1, 255));
        x = x ^ flip;
      end
      send_item(KIND_BYTE, x);
    end else if (pick < 73) begin
      // frame cut short
      sz = 8'($urandom_range(1, 8));
      send_item(KIND_BYTE, cfg_start);
      send_item(KIND_BYTE, sz);
      len = $urandom_range(0, sz - 1);
      repeat (len) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 81) begin
      send_item(KIND_BYTE, cfg_start);
      send_item(KIND_BYTE, 8'($urandom_range(FRAME_MAX + 1, 255)));
    end else if (pick < 90) begin
      send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      if (cfg_timeout != 16'd0 && cfg_timeout <= 16'd40)
        len = $urandom_range(1, 2 * cfg_timeout);
      else
        len = $urandom_range(1, 12);
      repeat (len) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_traffic(input int goal, input int tail_ticks);
    int stop_at;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) send_burst();
    send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    repeat (tail_ticks) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (results_if.valid && results_if.ready) begin
      if (deframed_q.size() == 0) begin
        $error("result item with none pending: %p", results_if.payload);
        fails++;
      end else begin
        want = deframed_q.pop_front();
        check_field("is_status", want.is_status, results_if.payload.is_status);
        check_field("byte_out", want.byte_out, results_if.payload.byte_out);
        check_field("byte_index", want.byte_index, results_if.payload.byte_index);
        check_field("frame_size", want.frame_size, results_if.payload.frame_size);
        check_field("status", want.status, results_if.payload.status);
      end
    end
  end

  initial begin : receiver
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        results_if.ready <= !(idle_on && $urandom_range(0, 99) < 21);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((bytes_if.valid && bytes_if.ready) || (results_if.valid && results_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    bytes_if.valid = 1'b0;
    bytes_if.payload = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_START_BYTE;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

    settle();
    program_regs(8'hA5, 16'd0);
    run_traffic(180, 4);

    // receiver stalls long enough for the block to back up
    settle();
    program_regs(8'hFF, 16'd3);
    hold_req = 1'b1;
    run_traffic(200, 2);

    // timeout drops below the running tick count, no idling on either side
    settle();
    idle_on = 1'b0;
    program_regs(8'h00, 16'd1);
    run_traffic(180, 1);

    settle();
    idle_on = 1'b1;
    program_regs(8'($urandom_range(0, 255)), 16'd40);
    run_traffic(200, 3);

    settle();
    program_regs(8'h5C, 16'hFFFF);
    run_traffic(150, 0);

    settle();
    repeat (10) @(posedge clk);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
